>>> sv/gql_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gql_pkg
// Shared types, register map and helpers of the glyph quad layout block.
// ----------------------------------------------------------------------------
package gql_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_UPPER_COLOR  = 3'd2;
  localparam logic [2:0] REG_LOWER_COLOR  = 3'd3;
  localparam logic [2:0] REG_FONT_HEIGHT  = 3'd4;
  localparam logic [2:0] REG_FIXED_FEED   = 3'd5;
  localparam logic [2:0] REG_ATLAS_WIDTH  = 3'd6;
  localparam logic [2:0] REG_ATLAS_HEIGHT = 3'd7;

  localparam int ADDR_W = 5;

  // input item functions
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  localparam logic [16:0] Q_ONE   = 17'h10000;
  localparam logic [16:0] PEN_MAX = 17'h1FFFF;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [31:0]        upper_color;
    logic [31:0]        lower_color;
    logic [7:0]         font_height;
    logic               fixed_feed;
    logic [12:0]        atlas_width;
    logic [12:0]        atlas_height;
  } cfg_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  w;
    logic [7:0]  h;
  } glyph_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/gql_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gql_cfg
// APB register file holding origin, colors, font height, feed mode and
// atlas size.
// ----------------------------------------------------------------------------
module gql_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gql_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output gql_pkg::cfg_t                    cfg
);

  logic [2:0] index;
  logic       wr;

  assign pready = 1'b1;
  assign index  = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x     <= 16'sd0;
      cfg.origin_y     <= 16'sd0;
      cfg.upper_color  <= 32'hFFFF_FFFF;
      cfg.lower_color  <= 32'hFFFF_FFFF;
      cfg.font_height  <= 8'd16;
      cfg.fixed_feed   <= 1'b0;
      cfg.atlas_width  <= 13'd1024;
      cfg.atlas_height <= 13'd1024;
    end else if (wr) begin
      unique case (index)
        gql_pkg::REG_ORIGIN_X:     cfg.origin_x     <= pwdata[15:0];
        gql_pkg::REG_ORIGIN_Y:     cfg.origin_y     <= pwdata[15:0];
        gql_pkg::REG_UPPER_COLOR:  cfg.upper_color  <= pwdata;
        gql_pkg::REG_LOWER_COLOR:  cfg.lower_color  <= pwdata;
        gql_pkg::REG_FONT_HEIGHT:  cfg.font_height  <= pwdata[7:0];
        gql_pkg::REG_FIXED_FEED:   cfg.fixed_feed   <= pwdata[0];
        gql_pkg::REG_ATLAS_WIDTH:  cfg.atlas_width  <= pwdata[12:0];
        gql_pkg::REG_ATLAS_HEIGHT: cfg.atlas_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      gql_pkg::REG_ORIGIN_X:     prdata = {16'd0, cfg.origin_x};
      gql_pkg::REG_ORIGIN_Y:     prdata = {16'd0, cfg.origin_y};
      gql_pkg::REG_UPPER_COLOR:  prdata = cfg.upper_color;
      gql_pkg::REG_LOWER_COLOR:  prdata = cfg.lower_color;
      gql_pkg::REG_FONT_HEIGHT:  prdata = {24'd0, cfg.font_height};
      gql_pkg::REG_FIXED_FEED:   prdata = {31'd0, cfg.fixed_feed};
      gql_pkg::REG_ATLAS_WIDTH:  prdata = {19'd0, cfg.atlas_width};
      gql_pkg::REG_ATLAS_HEIGHT: prdata = {19'd0, cfg.atlas_height};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/gql_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gql_store
// Glyph rectangle memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gql_store #(
  parameter int ENTRIES = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(ENTRIES)-1:0] waddr,
  input  wire gql_pkg::glyph_t            wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(ENTRIES)-1:0] raddr,
  output gql_pkg::glyph_t                 rdata
);

  gql_pkg::glyph_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/gql_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gql_div
// Texture coordinate divider: (numer << 16) / denom in Q1.16, saturated to
// one. Restoring division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module gql_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [12:0] numer,
  input  wire logic [12:0] denom,
  output logic             done,
  output logic [16:0]      quot
);

  logic        busy;
  logic [2:0]  cnt;
  logic [12:0] d;
  logic [12:0] r;
  logic [15:0] q;
  logic [12:0] dd;
  logic [13:0] r1, r1s, r2, r2s;
  logic        b1, b2;

  // a zero atlas size divides as one
  assign dd = (denom == 13'd0) ? 13'd1 : denom;

  always_comb begin
    r1  = {r, 1'b0};
    b1  = r1 >= {1'b0, d};
    r1s = b1 ? r1 - {1'b0, d} : r1;
    r2  = {r1s[12:0], 1'b0};
    b2  = r2 >= {1'b0, d};
    r2s = b2 ? r2 - {1'b0, d} : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        d   <= dd;
        r   <= numer;
        q   <= 16'd0;
        cnt <= 3'd0;
        // numer >= denom means the quotient is at least one: saturate
        if (numer >= dd) begin
          quot <= gql_pkg::Q_ONE;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        r   <= r2s[12:0];
        q   <= {q[13:0], b1, b2};
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= {1'b0, q[13:0], b1, b2};
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/glyph_quad_layout.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_quad_layout
// Text-to-quad layout engine: turns character codes into four textured,
// colored vertices each, using a glyph rectangle memory.
// ----------------------------------------------------------------------------
// A load word writes one glyph rectangle. A draw word reads the glyph memory,
// forms positions and the pen advance, runs the four texture divisions
// through the one shared divider (two quotient bits per cycle, while a
// coordinate that saturates to one needs no division steps), and then hands
// out the four vertices as the output takes them.
// Dropped characters and codes beyond the memory produce no vertices. The glyph
// memory is not cleared after reset; draw only codes that have been loaded.
// Write configuration only while the block is idle.
module glyph_quad_layout #(
  parameter int MAX_CHARS     = 256,
  parameter int STORE_ENTRIES = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gql_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        func,
  input  wire logic [15:0]                 char_code,
  input  wire logic [11:0]                 rect_x,
  input  wire logic [11:0]                 rect_y,
  input  wire logic [7:0]                  rect_w,
  input  wire logic [7:0]                  rect_h,
  input  wire logic                        first,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [9:0]                       vertex_index,
  output logic signed [15:0]               screen_x,
  output logic signed [15:0]               screen_y,
  output logic [31:0]                      color,
  output logic [16:0]                      tex_u,
  output logic [16:0]                      tex_v,
  output logic                             last
);

  localparam int AW = $clog2(STORE_ENTRIES);
  localparam int SW = $clog2(MAX_CHARS + 1);
  localparam int VW = (SW + 2 > 10) ? SW + 2 : 10;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  gql_pkg::cfg_t   cfg;
  gql_pkg::glyph_t wr_glyph;
  gql_pkg::glyph_t g;

  logic [1:0]  state;
  logic [16:0] pen;
  logic [SW-1:0] slot_count;
  logic [SW-1:0] cur_slot;
  logic        ascii;
  logic [1:0]  corner;
  logic [1:0]  div_sel;
  logic        div_start;
  logic        div_done;
  logic [16:0] div_quot;
  logic [12:0] div_numer;
  logic [12:0] div_denom;
  logic [16:0] tex_q [4];
  logic signed [15:0] sx_l, sx_r, sy_t, sy_b;

  logic          in_acc;
  logic          in_range;
  logic          st_we;
  logic          st_re;
  logic [16:0]   pen_eff;
  logic [SW-1:0] slot_eff;
  logic signed [18:0] xl, xr, yb;
  logic [7:0]    feed;
  logic [17:0]   pen_sum;
  logic          load_out;
  logic [VW-1:0] vidx_full;

  gql_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready = (state == ST_IDLE) && !rst;
  assign in_acc   = in_valid && in_ready;
  assign in_range = {1'b0, char_code} < 17'(STORE_ENTRIES);
  assign st_we    = in_acc && (func == gql_pkg::FUNC_LOAD) && in_range;
  assign st_re    = in_acc && (func == gql_pkg::FUNC_DRAW) && in_range;

  assign wr_glyph.x = rect_x;
  assign wr_glyph.y = rect_y;
  assign wr_glyph.w = rect_w;
  assign wr_glyph.h = rect_h;

  gql_store #(
    .ENTRIES (STORE_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (char_code[AW-1:0]),
    .wdata (wr_glyph),
    .re    (st_re),
    .raddr (char_code[AW-1:0]),
    .rdata (g)
  );

  // a new string clears pen and slot count before the character is handled
  assign pen_eff  = first ? 17'd0 : pen;
  assign slot_eff = first ? '0 : slot_count;

  always_comb begin
    xl      = 19'(cfg.origin_x) + $signed({2'b00, pen});
    xr      = xl + $signed({11'd0, g.w});
    yb      = 19'(cfg.origin_y) + $signed({11'd0, g.h});
    feed    = (cfg.fixed_feed && ascii) ? {1'b0, cfg.font_height[7:1]} : g.w;
    pen_sum = {1'b0, pen} + 18'(feed) + 18'd1;
  end

  always_comb begin
    case (div_sel)
      2'd0:    div_numer = {1'b0, g.x};
      2'd1:    div_numer = 13'({1'b0, g.x} + {5'd0, g.w});
      2'd2:    div_numer = {1'b0, g.y};
      default: div_numer = 13'({1'b0, g.y} + {5'd0, g.h});
    endcase
    div_denom = div_sel[1] ? cfg.atlas_height : cfg.atlas_width;
  end

  gql_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign load_out  = (state == ST_EMIT) && (!out_valid || out_ready);
  assign vidx_full = VW'({cur_slot, corner});

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pen        <= 17'd0;
      slot_count <= '0;
      div_start  <= 1'b0;
      div_sel    <= 2'd0;
      corner     <= 2'd0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (func == gql_pkg::FUNC_DRAW)) begin
            pen        <= pen_eff;
            slot_count <= slot_eff;
            cur_slot   <= slot_eff;
            ascii      <= char_code < 16'd128;
            // drop past the slot limit; out-of-store codes burn a slot only
            if (slot_eff < SW'(MAX_CHARS)) begin
              slot_count <= slot_eff + SW'(1);
              if (in_range) begin
                state <= ST_CALC;
              end
            end
          end
        end
        ST_CALC: begin
          sx_l      <= gql_pkg::sat16(xl);
          sx_r      <= gql_pkg::sat16(xr);
          sy_t      <= cfg.origin_y;
          sy_b      <= gql_pkg::sat16(yb);
          pen       <= (pen_sum > {1'b0, gql_pkg::PEN_MAX}) ? gql_pkg::PEN_MAX
                                                            : pen_sum[16:0];
          div_sel   <= 2'd0;
          div_start <= 1'b1;
          state     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            tex_q[div_sel] <= div_quot;
            if (div_sel == 2'd3) begin
              corner <= 2'd0;
              state  <= ST_EMIT;
            end else begin
              div_sel   <= div_sel + 2'd1;
              div_start <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            corner <= corner + 2'd1;
            if (corner == 2'd3) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register: one vertex word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      vertex_index <= vidx_full[9:0];
      screen_x     <= corner[0] ? sx_r : sx_l;
      screen_y     <= corner[1] ? sy_b : sy_t;
      color        <= corner[1] ? cfg.lower_color : cfg.upper_color;
      tex_u        <= corner[0] ? tex_q[1] : tex_q[0];
      tex_v        <= corner[1] ? tex_q[3] : tex_q[2];
      last         <= (corner == 2'd3);
    end
  end

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count <= SW'(MAX_CHARS))
    else $error("slot count beyond limit");

  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (vertex_index[1:0] == 2'b11))
    else $error("last flag on a vertex other than right-bottom");

  a_pen_hold: assert property (@(posedge clk) disable iff (rst)
    ((state != ST_CALC) && !in_acc) |=> $stable(pen))
    else $error("pen moved outside a draw");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the division phase");

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the glyph quad layout engine. Glyph rectangles are
// loaded and characters drawn through the valid/ready input; every vertex on
// the output is compared against a layout model kept inside the bench. The
// register port is set between phases: reset values, both origin extremes,
// tiny and full atlas sizes, fixed feed on and off, then random settings for
// one full string that runs into the slot limit.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_CHARS     = 256;
  localparam int STORE_ENTRIES = 1024;
  localparam int DRAIN_CYCLES  = 60;

  typedef struct packed {
    logic        op;
    logic [15:0] code;
    logic [11:0] rx;
    logic [11:0] ry;
    logic [7:0]  rw;
    logic [7:0]  rh;
    logic        start;
  } word_t;

  typedef struct packed {
    logic [9:0]         idx;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [31:0]        rgba;
    logic [16:0]        u;
    logic [16:0]        v;
    logic               fin;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [gql_pkg::ADDR_W-1:0]  paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                func = gql_pkg::FUNC_LOAD;
  logic [15:0]         char_code = '0;
  logic [11:0]         rect_x = '0;
  logic [11:0]         rect_y = '0;
  logic [7:0]          rect_w = '0;
  logic [7:0]          rect_h = '0;
  logic                first = 1'b0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [9:0]          vertex_index;
  logic signed [15:0]  screen_x;
  logic signed [15:0]  screen_y;
  logic [31:0]         color;
  logic [16:0]         tex_u;
  logic [16:0]         tex_v;
  logic                last;

  glyph_quad_layout #(
    .MAX_CHARS     (MAX_CHARS),
    .STORE_ENTRIES (STORE_ENTRIES)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .char_code    (char_code),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .rect_w       (rect_w),
    .rect_h       (rect_h),
    .first        (first),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vertex_index (vertex_index),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .color        (color),
    .tex_u        (tex_u),
    .tex_v        (tex_v),
    .last         (last)
  );

  // text words waiting to go out, and vertices the layout says must come back
  word_t   text_words[$];
  vertex_t expected_vertices[$];

  // layout model state
  gql_pkg::glyph_t glyph_mem [STORE_ENTRIES];
  logic [16:0]     pen_pos;
  int              slots_used;
  gql_pkg::cfg_t   cfg_shadow;

  // stimulus bookkeeping
  bit          loaded_flag [STORE_ENTRIES];
  int          loaded_list[$];
  int          words_queued = 0;
  int          words_accepted = 0;
  int          loads_taken = 0;
  int          draws_taken = 0;
  int          vertices_checked = 0;
  int          settings_used = 0;
  int          errors = 0;
  int          stall_left = 0;
  bit          no_gaps = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Timeout: layout engine stopped making progress");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  function automatic logic signed [15:0] clamp_px(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic logic [16:0] texel_q16(input int unsigned pos, input logic [12:0] size);
    longint unsigned div;
    longint unsigned q;
    div = (size == '0) ? 64'd1 : 64'(size);
    q = (64'(pos) << 16) / div;
    return (q > 64'd65536) ? gql_pkg::Q_ONE : q[16:0];
  endfunction

  // apply one accepted word to the layout model
  function automatic void lay_out_glyph(input word_t wd);
    gql_pkg::glyph_t g;
    vertex_t         vx;
    int              xl, xr, yt, yb, slot, adv;
    logic [16:0]     ul, ur, vt, vb;
    if (wd.op == gql_pkg::FUNC_LOAD) begin
      loads_taken++;
      if (wd.code < STORE_ENTRIES) begin
        glyph_mem[wd.code[9:0]] = '{x: wd.rx, y: wd.ry, w: wd.rw, h: wd.rh};
      end
      return;
    end
    draws_taken++;
    if (wd.start) begin
      pen_pos = '0;
      slots_used = 0;
    end
    if (slots_used >= MAX_CHARS) return;
    slot = slots_used;
    slots_used++;
    if (wd.code >= STORE_ENTRIES) return;
    g = glyph_mem[wd.code[9:0]];
    xl = int'($signed(cfg_shadow.origin_x)) + int'(pen_pos);
    xr = xl + int'(g.w);
    yt = int'($signed(cfg_shadow.origin_y));
    yb = yt + int'(g.h);
    ul = texel_q16(g.x, cfg_shadow.atlas_width);
    ur = texel_q16(int'(g.x) + int'(g.w), cfg_shadow.atlas_width);
    vt = texel_q16(g.y, cfg_shadow.atlas_height);
    vb = texel_q16(int'(g.y) + int'(g.h), cfg_shadow.atlas_height);
    for (int c = 0; c < 4; c++) begin
      vx.idx  = 10'(slot * 4 + c);
      vx.sx   = clamp_px(c[0] ? xr : xl);
      vx.sy   = clamp_px(c[1] ? yb : yt);
      vx.rgba = c[1] ? cfg_shadow.lower_color : cfg_shadow.upper_color;
      vx.u    = c[0] ? ur : ul;
      vx.v    = c[1] ? vb : vt;
      vx.fin  = (c == 3);
      expected_vertices.push_back(vx);
    end
    if (cfg_shadow.fixed_feed && wd.code < 128) adv = int'(cfg_shadow.font_height) / 2;
    else adv = int'(g.w);
    adv = int'(pen_pos) + adv + 1;
    pen_pos = (adv > 131071) ? gql_pkg::PEN_MAX : 17'(adv);
  endfunction

  // driver: hold the word until taken, then offer the next or idle
  always @(posedge clk) begin : drive
    word_t nxt;
    logic  offer;
    offer = in_valid;
    if (rst) begin
      pen_pos = '0;
      slots_used = 0;
      cfg_shadow = '{origin_x: 16'sd0, origin_y: 16'sd0, upper_color: 32'hFFFF_FFFF,
                     lower_color: 32'hFFFF_FFFF, font_height: 8'd16, fixed_feed: 1'b0,
                     atlas_width: 13'd1024, atlas_height: 13'd1024};
      offer = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        lay_out_glyph({func, char_code, rect_x, rect_y, rect_w, rect_h, first});
        words_accepted++;
        offer = 1'b0;
      end
      if (!offer && text_words.size() > 0 && (no_gaps || $urandom_range(99) >= 24)) begin
        nxt = text_words.pop_front();
        func      <= nxt.op;
        char_code <= nxt.code;
        rect_x    <= nxt.rx;
        rect_y    <= nxt.ry;
        rect_w    <= nxt.rw;
        rect_h    <= nxt.rh;
        first     <= nxt.start;
        offer = 1'b1;
      end
    end
    in_valid <= offer;
  end

  task automatic check_field(input string name, input logic [31:0] got_v,
                             input logic [31:0] want_v, input logic [9:0] at);
    if (got_v !== want_v) begin
      flag_error($sformatf("vertex %0d %s got %h want %h", at, name, got_v, want_v));
    end
  endtask

  // monitor: compare each vertex taken, and throttle out_ready
  always @(posedge clk) begin : watch
    vertex_t want;
    logic    take;
    if (!rst && out_valid && out_ready) begin
      vertices_checked++;
      if (expected_vertices.size() == 0) begin
        flag_error($sformatf("vertex %0d arrived with nothing expected", vertex_index));
      end else begin
        want = expected_vertices.pop_front();
        check_field("vertex_index", 32'(vertex_index), 32'(want.idx), want.idx);
        check_field("screen_x", 32'(screen_x), 32'(want.sx), want.idx);
        check_field("screen_y", 32'(screen_y), 32'(want.sy), want.idx);
        check_field("color", color, want.rgba, want.idx);
        check_field("tex_u", 32'(tex_u), 32'(want.u), want.idx);
        check_field("tex_v", 32'(tex_v), 32'(want.v), want.idx);
        check_field("last", 32'(last), 32'(want.fin), want.idx);
      end
      // hold off long enough for the input side to back up
      if (vertices_checked == 120) stall_left = 600;
    end
    if (stall_left > 0) begin
      stall_left--;
      take = 1'b0;
    end else begin
      take = no_gaps || ($urandom_range(99) >= 24);
    end
    out_ready <= take;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      gql_pkg::REG_ORIGIN_X:     cfg_shadow.origin_x = val[15:0];
      gql_pkg::REG_ORIGIN_Y:     cfg_shadow.origin_y = val[15:0];
      gql_pkg::REG_UPPER_COLOR:  cfg_shadow.upper_color = val;
      gql_pkg::REG_LOWER_COLOR:  cfg_shadow.lower_color = val;
      gql_pkg::REG_FONT_HEIGHT:  cfg_shadow.font_height = val[7:0];
      gql_pkg::REG_FIXED_FEED:   cfg_shadow.fixed_feed = val[0];
      gql_pkg::REG_ATLAS_WIDTH:  cfg_shadow.atlas_width = val[12:0];
      gql_pkg::REG_ATLAS_HEIGHT: cfg_shadow.atlas_height = val[12:0];
      default: ;
    endcase
  endtask

  task automatic write_setting(input int ox, input int oy, input logic [31:0] top_rgba,
                               input logic [31:0] bot_rgba, input int fh, input bit fixed,
                               input int aw, input int ah);
    write_reg(gql_pkg::REG_ORIGIN_X, 32'(ox));
    write_reg(gql_pkg::REG_ORIGIN_Y, 32'(oy));
    write_reg(gql_pkg::REG_UPPER_COLOR, top_rgba);
    write_reg(gql_pkg::REG_LOWER_COLOR, bot_rgba);
    write_reg(gql_pkg::REG_FONT_HEIGHT, 32'(fh));
    write_reg(gql_pkg::REG_FIXED_FEED, 32'(fixed));
    write_reg(gql_pkg::REG_ATLAS_WIDTH, 32'(aw));
    write_reg(gql_pkg::REG_ATLAS_HEIGHT, 32'(ah));
    settings_used++;
  endtask

  function automatic int pick_origin();
    if ($urandom_range(3) == 0) return int'($urandom_range(65535));
    return int'($urandom_range(400)) - 200;
  endfunction

  function automatic int pick_atlas();
    case ($urandom_range(3))
      0:       return int'($urandom_range(16, 1));
      1:       return 4096;
      default: return int'($urandom_range(4096, 256));
    endcase
  endfunction

  function automatic logic [15:0] beyond_code();
    return 16'($urandom_range(65535, STORE_ENTRIES));
  endfunction

  function automatic void push_load(input logic [15:0] code, input int x, input int y,
                                    input int w, input int h, input bit start);
    text_words.push_back('{op: gql_pkg::FUNC_LOAD, code: code, rx: 12'(x), ry: 12'(y),
                           rw: 8'(w), rh: 8'(h), start: start});
    words_queued++;
    if (code < STORE_ENTRIES && !loaded_flag[code[9:0]]) begin
      loaded_flag[code[9:0]] = 1'b1;
      loaded_list.push_back(int'(code));
    end
  endfunction

  function automatic void push_draw(input logic [15:0] code, input bit start);
    text_words.push_back('{op: gql_pkg::FUNC_DRAW, code: code,
                           rx: 12'($urandom_range(4095)), ry: 12'($urandom_range(4095)),
                           rw: 8'($urandom_range(255)), rh: 8'($urandom_range(255)),
                           start: start});
    words_queued++;
  endfunction

  // one string of n draws over loaded glyphs and stray codes; now and then a
  // fresh glyph is loaded and drawn right after
  function automatic void queue_long_string(input int n);
    logic [15:0] code;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) begin
        code = 16'($urandom_range(STORE_ENTRIES - 1));
        push_load(code, $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(255), $urandom_range(255), $urandom_range(1));
      end else if ($urandom_range(9) == 0) begin
        code = beyond_code();
      end else begin
        code = 16'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
      end
      push_draw(code, i == 0);
    end
  endfunction

  // wait for the block to drain before touching registers or ending
  task automatic settle();
    while (words_accepted != words_queued) @(posedge clk);
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: loads at the field extremes, stray loads, first on a load
    push_load(16'd0, 0, 0, 0, 0, 1'b0);
    push_load(16'd1023, 4095, 4095, 255, 255, 1'b1);
    push_load(16'd65, 100, 200, 10, 20, 1'b0);
    push_load(16'd127, 2048, 1024, 128, 64, 1'b0);
    push_load(16'd128, 1, 4094, 1, 254, 1'b0);
    push_load(16'd200, 1000, 50, 255, 8, 1'b0);
    push_load(16'(STORE_ENTRIES), 1, 1, 1, 1, 1'b0);
    push_load(16'hFFFF, 4095, 4095, 255, 255, 1'b1);
    push_draw(16'd0, 1'b1);
    push_draw(16'd1023, 1'b0);
    push_draw(16'd65, 1'b0);
    push_draw(16'd2000, 1'b0);
    push_draw(16'd200, 1'b0);
    push_draw(16'd127, 1'b0);
    push_draw(16'd128, 1'b0);
    settle();

    // bottom-right corner origin, one-texel atlas, tallest font with fixed feed
    write_setting(32767, 32767, 32'h0000_0000, 32'h1234_5678, 255, 1'b1, 1, 1);
    push_draw(16'd65, 1'b1);
    push_draw(16'd200, 1'b0);
    push_draw(16'd1023, 1'b0);
    push_draw(16'd0, 1'b0);
    push_draw(16'd127, 1'b0);
    settle();

    // top-left extreme, largest atlas, zero font height
    write_setting(-32768, -32768, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 0, 1'b1, 4096, 4096);
    push_draw(16'd127, 1'b1);
    push_draw(16'd128, 1'b0);
    push_draw(16'd1023, 1'b0);
    push_draw(16'd65, 1'b0);
    settle();

    // fill every slot with random settings, then check the drops after it
    write_setting(pick_origin(), pick_origin(), $urandom(), $urandom(),
                  $urandom_range(255), $urandom_range(1), pick_atlas(), pick_atlas());
    no_gaps = 1'b1;
    queue_long_string(MAX_CHARS);
    push_draw(16'd200, 1'b0);
    push_draw(beyond_code(), 1'b0);
    push_draw(16'd65, 1'b1);
    // back to random idling for the second half of the string
    while (words_accepted < words_queued - 140) @(posedge clk);
    no_gaps = 1'b0;
    settle();

    $display("Covered %0d glyph loads and %0d draws under %0d register settings,",
             loads_taken, draws_taken, settings_used);
    $display("including slot overflow and saturation; %0d vertices checked, %0d mismatches.",
             vertices_checked, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
